### src/dsbt_pkg.sv
// ----------------------------------------------------------------------------
// dsbt_pkg
// Shared types and codes of the DHCP snooping binding table.
// ----------------------------------------------------------------------------
package dsbt_pkg;

    localparam logic [2:0] FN_LOOKUP  = 3'd0;
    localparam logic [2:0] FN_INSERT  = 3'd1;
    localparam logic [2:0] FN_DELETE  = 3'd2;
    localparam logic [2:0] FN_REFRESH = 3'd3;
    localparam logic [2:0] FN_TICK    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    localparam int SUM_W = 11;

    typedef struct packed {
        logic [4:0]  hw_len;
        logic [7:0]  bind_kind;
        logic [7:0]  bind_state;
        logic [31:0] lease_secs;
        logic [11:0] vlan_id;
        logic [15:0] port_index;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
    } req_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [4:0]  hw_len;
        logic [7:0]  bind_kind;
        logic [7:0]  bind_state;
        logic [31:0] lease_secs;
        logic [11:0] vlan_id;
        logic [15:0] port_index;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
    } entry_t;

    typedef struct packed {
        logic [6:0]  aged_count;
        logic [31:0] bound_time;
        logic [4:0]  found_hw_len;
        logic [7:0]  found_kind;
        logic [7:0]  found_state;
        logic [31:0] found_lease;
        logic [11:0] found_vlan;
        logic [15:0] found_port;
        logic [31:0] found_ip;
        logic        hit;
        logic [1:0]  status;
    } res_t;

endpackage

### src/dsbt_mod.sv
// ----------------------------------------------------------------------------
// dsbt_mod
// Remainder of the MAC byte sum by the bucket count, by reciprocal multiply.
// ----------------------------------------------------------------------------
module dsbt_mod #(
    parameter int MODULUS = 16,
    localparam int REMW = (MODULUS > 1) ? $clog2(MODULUS) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [dsbt_pkg::SUM_W-1:0] value,
    output logic                       done,
    output logic [REMW-1:0]            rem
);

    // quotient estimate is exact or one low for any sum below 2^SUM_W
    localparam int SHIFT = 22;
    localparam int RECIP = (1 << SHIFT) / MODULUS;
    localparam int PRODW = dsbt_pkg::SUM_W + SHIFT + 1;

    logic [dsbt_pkg::SUM_W-1:0] val_reg;
    logic [dsbt_pkg::SUM_W-1:0] quo_reg;
    logic [REMW-1:0]            rem_reg;
    logic                       load_reg;
    logic                       quo_ok_reg;
    logic                       done_reg;
    logic [PRODW-1:0]           prod;
    logic [dsbt_pkg::SUM_W:0]   diff;
    logic [dsbt_pkg::SUM_W:0]   rem_next;

    always_comb begin
        prod = PRODW'(val_reg) * PRODW'(RECIP);
        diff = {1'b0, val_reg} - (dsbt_pkg::SUM_W+1)'(int'(quo_reg) * MODULUS);
        if (diff >= (dsbt_pkg::SUM_W+1)'(MODULUS)) begin
            rem_next = diff - (dsbt_pkg::SUM_W+1)'(MODULUS);
        end else begin
            rem_next = diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg   <= 1'b0;
            quo_ok_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            load_reg   <= start;
            quo_ok_reg <= load_reg;
            done_reg   <= quo_ok_reg;
            if (start) begin
                val_reg <= value;
            end
            if (load_reg) begin
                quo_reg <= prod[SHIFT +: dsbt_pkg::SUM_W];
            end
            if (quo_ok_reg) begin
                rem_reg <= rem_next[REMW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### src/dsbt_ram.sv
// ----------------------------------------------------------------------------
// dsbt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dsbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/dhcp_snoop_binding_table.sv
// ----------------------------------------------------------------------------
// dhcp_snoop_binding_table
// DHCP snooping binding table, hashed by client MAC, kept in block RAM.
// ----------------------------------------------------------------------------
// s_ words carry one command (tuser = function code); every command returns
// exactly one m_ word. Entries sit in a data RAM and a valid/rank RAM of
// BUCKETS*WAYS rows.
// Lookup/delete/refresh/insert: bucket hashing, a scan that reads and then
// evaluates each way of the bucket, a decide step, a rank update of each
// way for a successful insert or delete, and the load of the output register.
// Tick: for every bucket, a read and evaluate of each way, then an update of
// each way's rank and valid bit. Unknown codes go straight to the output register.
// One command is in work at a time; s_tready returns the cycle after the
// result is loaded.
// After reset a clearing pass writes every row of the valid/rank RAM with
// s_tready low.
// The result is held in an output register; a stalled receiver holds the
// next result in the block until m_tready returns.
// ----------------------------------------------------------------------------
module dhcp_snoop_binding_table #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mac_addr, ip_addr, port_index, vlan_id, lease_secs, bind_state, bind_kind, hw_len
    input  logic [167:0] s_tdata,
    // func
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, hit, found_ip, found_port, found_vlan, found_lease, found_state,
    // found_kind, found_hw_len, bound_time, aged_count
    output logic [159:0] m_tdata
);

    localparam int SLOTS = BUCKETS * WAYS;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EW    = $bits(dsbt_pkg::entry_t);
    localparam int RESW  = $bits(dsbt_pkg::res_t);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_RD, S_EV, S_DECIDE, S_FIX,
        S_TRD, S_TEV, S_TFIX, S_DONE
    } state_t;

    state_t               state_reg;
    dsbt_pkg::req_t       req_reg;
    logic [2:0]           func_reg;
    logic [31:0]          now_reg;
    logic [BW-1:0]        bucket_reg;
    logic [WW-1:0]        way_reg;
    logic [AW-1:0]        clr_reg;
    logic                 found_reg;
    logic [WW-1:0]        best_way_reg;
    logic [WW-1:0]        best_rank_reg;
    dsbt_pkg::entry_t     best_reg;
    logic                 free_found_reg;
    logic [WW-1:0]        free_way_reg;
    logic [6:0]           aged_reg;
    logic                 v_reg [WAYS];
    logic [WW-1:0]        r_reg [WAYS];
    logic                 x_reg [WAYS];
    dsbt_pkg::res_t       res_reg;
    logic                 m_tvalid_reg;
    logic [RESW-1:0]      m_tdata_reg;

    dsbt_pkg::req_t       s_req;
    logic [dsbt_pkg::SUM_W-1:0] byte_sum;
    logic                 mod_start;
    logic                 mod_done;
    logic [BW-1:0]        mod_rem;

    logic [AW-1:0]        rd_addr;
    logic                 meta_we;
    logic [AW-1:0]        meta_waddr;
    logic [WW:0]          meta_wdata;
    logic [WW:0]          meta_rdata;
    logic                 data_we;
    logic [AW-1:0]        data_waddr;
    dsbt_pkg::entry_t     data_wdata;
    logic [EW-1:0]        data_rdata;
    dsbt_pkg::entry_t     rd_entry;
    logic                 rd_v;
    logic [WW-1:0]        rd_r;
    logic                 hit_now;
    logic                 expire_now;
    logic [WW:0]          older_cnt;
    logic                 last_way;
    logic                 ref_pass;
    dsbt_pkg::entry_t     new_entry;
    dsbt_pkg::entry_t     upd_entry;
    logic                 accept;

    assign s_req    = dsbt_pkg::req_t'(s_tdata[$bits(dsbt_pkg::req_t)-1:0]);
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign last_way = (way_reg == WW'(WAYS - 1));

    always_comb begin
        byte_sum = '0;
        for (int i = 0; i < 6; i++) begin
            byte_sum = byte_sum + dsbt_pkg::SUM_W'(s_req.mac_addr[8*i +: 8]);
        end
    end

    assign mod_start = accept && (s_tuser <= dsbt_pkg::FN_REFRESH);

    dsbt_mod #(.MODULUS(BUCKETS)) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .value   (byte_sum),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b, input logic [WW-1:0] w);
        slot_addr = AW'(int'(b) * WAYS + int'(w));
    endfunction

    assign rd_addr  = slot_addr(bucket_reg, way_reg);
    assign rd_entry = dsbt_pkg::entry_t'(data_rdata);
    assign rd_v     = meta_rdata[WW];
    assign rd_r     = meta_rdata[WW-1:0];
    assign hit_now  = rd_v && (rd_entry.mac_addr == req_reg.mac_addr) &&
                      (!found_reg || (rd_r < best_rank_reg));
    assign expire_now = rd_v &&
        ({1'b0, rd_entry.stamp} + {1'b0, rd_entry.lease_secs} <= {1'b0, now_reg});
    assign ref_pass = (best_reg.vlan_id == req_reg.vlan_id) &&
                      (best_reg.hw_len == req_reg.hw_len) &&
                      ((req_reg.port_index == 16'd0) ||
                       (best_reg.port_index == req_reg.port_index));

    always_comb begin
        new_entry.mac_addr   = req_reg.mac_addr;
        new_entry.ip_addr    = req_reg.ip_addr;
        new_entry.port_index = req_reg.port_index;
        new_entry.vlan_id    = req_reg.vlan_id;
        new_entry.lease_secs = req_reg.lease_secs;
        new_entry.bind_state = req_reg.bind_state;
        new_entry.bind_kind  = req_reg.bind_kind;
        new_entry.hw_len     = req_reg.hw_len;
        new_entry.stamp      = now_reg;
        upd_entry            = best_reg;
        upd_entry.ip_addr    = req_reg.ip_addr;
        upd_entry.lease_secs = req_reg.lease_secs;
        upd_entry.bind_state = req_reg.bind_state;
        upd_entry.stamp      = now_reg;
    end

    always_comb begin
        older_cnt = '0;
        for (int j = 0; j < WAYS; j++) begin
            if (x_reg[j] && (r_reg[j] < r_reg[way_reg])) begin
                older_cnt = older_cnt + (WW+1)'(1);
            end
        end
    end

    // valid/rank RAM writes
    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = rd_addr;
        meta_wdata = {v_reg[way_reg], r_reg[way_reg]};
        case (state_reg)
            S_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = '0;
            end
            S_FIX: begin
                meta_we = 1'b1;
                if (func_reg == dsbt_pkg::FN_DELETE) begin
                    if (way_reg == best_way_reg) begin
                        meta_wdata = '0;
                    end else if (v_reg[way_reg] && (r_reg[way_reg] > best_rank_reg)) begin
                        meta_wdata = {1'b1, r_reg[way_reg] - WW'(1)};
                    end
                end else begin
                    if (way_reg == free_way_reg) begin
                        meta_wdata = '0;
                        meta_wdata[WW] = 1'b1;
                    end else if (v_reg[way_reg]) begin
                        meta_wdata = {1'b1, r_reg[way_reg] + WW'(1)};
                    end
                end
            end
            S_TFIX: begin
                meta_we = 1'b1;
                if (x_reg[way_reg]) begin
                    meta_wdata = '0;
                end else begin
                    meta_wdata = {v_reg[way_reg], r_reg[way_reg] - older_cnt[WW-1:0]};
                end
            end
            default: begin
                meta_we = 1'b0;
            end
        endcase
    end

    // data RAM writes
    always_comb begin
        data_we    = 1'b0;
        data_waddr = rd_addr;
        data_wdata = new_entry;
        case (state_reg)
            S_DECIDE: begin
                data_waddr = slot_addr(bucket_reg, best_way_reg);
                data_wdata = upd_entry;
                data_we    = (func_reg == dsbt_pkg::FN_REFRESH) && found_reg && ref_pass;
            end
            S_FIX: begin
                data_we = (func_reg == dsbt_pkg::FN_INSERT) && (way_reg == free_way_reg);
            end
            default: begin
                data_we = 1'b0;
            end
        endcase
    end

    dsbt_ram #(.WIDTH(WW + 1), .DEPTH(SLOTS)) u_meta (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (rd_addr),
        .rdata (meta_rdata)
    );

    dsbt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_data (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (rd_addr),
        .rdata (data_rdata)
    );

    function automatic dsbt_pkg::res_t entry_res(input dsbt_pkg::entry_t e,
                                                 input logic [1:0] st, input logic h);
        dsbt_pkg::res_t r;
        r.status       = st;
        r.hit          = h;
        r.found_ip     = e.ip_addr;
        r.found_port   = e.port_index;
        r.found_vlan   = e.vlan_id;
        r.found_lease  = e.lease_secs;
        r.found_state  = e.bind_state;
        r.found_kind   = e.bind_kind;
        r.found_hw_len = e.hw_len;
        r.bound_time   = e.stamp;
        r.aged_count   = '0;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            now_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(SLOTS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        req_reg        <= s_req;
                        func_reg       <= s_tuser;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        way_reg        <= '0;
                        bucket_reg     <= '0;
                        aged_reg       <= '0;
                        res_reg        <= '0;
                        if (s_tuser == dsbt_pkg::FN_TICK) begin
                            now_reg   <= now_reg + 32'd1;
                            state_reg <= S_TRD;
                        end else if (s_tuser <= dsbt_pkg::FN_REFRESH) begin
                            state_reg <= S_HASH;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_HASH: begin
                    if (mod_done) begin
                        bucket_reg <= mod_rem;
                        state_reg  <= S_RD;
                    end
                end
                S_RD: begin
                    state_reg <= S_EV;
                end
                S_EV: begin
                    v_reg[way_reg] <= rd_v;
                    r_reg[way_reg] <= rd_r;
                    if (hit_now) begin
                        found_reg     <= 1'b1;
                        best_way_reg  <= way_reg;
                        best_rank_reg <= rd_r;
                        best_reg      <= rd_entry;
                    end
                    if (!rd_v && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_way_reg   <= way_reg;
                    end
                    if (last_way) begin
                        way_reg   <= '0;
                        state_reg <= S_DECIDE;
                    end else begin
                        way_reg   <= way_reg + WW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_DECIDE: begin
                    state_reg <= S_DONE;
                    case (func_reg)
                        dsbt_pkg::FN_INSERT: begin
                            if (free_found_reg) begin
                                res_reg   <= entry_res(new_entry, dsbt_pkg::ST_OK, 1'b0);
                                state_reg <= S_FIX;
                            end else begin
                                res_reg.status <= dsbt_pkg::ST_FULL;
                            end
                        end
                        dsbt_pkg::FN_REFRESH: begin
                            if (!found_reg) begin
                                res_reg.status <= dsbt_pkg::ST_NOTFOUND;
                            end else if (ref_pass) begin
                                res_reg <= entry_res(upd_entry, dsbt_pkg::ST_OK, 1'b1);
                            end else begin
                                res_reg <= entry_res(best_reg, dsbt_pkg::ST_MISMATCH, 1'b1);
                            end
                        end
                        default: begin
                            if (!found_reg) begin
                                res_reg.status <= dsbt_pkg::ST_NOTFOUND;
                            end else begin
                                res_reg <= entry_res(best_reg, dsbt_pkg::ST_OK, 1'b1);
                                if (func_reg == dsbt_pkg::FN_DELETE) begin
                                    state_reg <= S_FIX;
                                end
                            end
                        end
                    endcase
                end
                S_FIX: begin
                    if (last_way) begin
                        state_reg <= S_DONE;
                    end else begin
                        way_reg <= way_reg + WW'(1);
                    end
                end
                S_TRD: begin
                    state_reg <= S_TEV;
                end
                S_TEV: begin
                    v_reg[way_reg] <= rd_v;
                    r_reg[way_reg] <= rd_r;
                    x_reg[way_reg] <= expire_now;
                    if (expire_now && (aged_reg != 7'd127)) begin
                        aged_reg <= aged_reg + 7'd1;
                    end
                    if (last_way) begin
                        way_reg   <= '0;
                        state_reg <= S_TFIX;
                    end else begin
                        way_reg   <= way_reg + WW'(1);
                        state_reg <= S_TRD;
                    end
                end
                S_TFIX: begin
                    if (last_way) begin
                        way_reg <= '0;
                        if (bucket_reg == BW'(BUCKETS - 1)) begin
                            res_reg.aged_count <= aged_reg;
                            state_reg          <= S_DONE;
                        end else begin
                            bucket_reg <= bucket_reg + BW'(1);
                            state_reg  <= S_TRD;
                        end
                    end else begin
                        way_reg <= way_reg + WW'(1);
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(160 - RESW)'(0), m_tdata_reg};

endmodule

### tb/dhcp_snoop_binding_table_tb.sv
// ----------------------------------------------------------------------------
// dhcp_snoop_binding_table_tb
// Self-checking bench: drives command words with random gaps, predicts every
// result word from a behavioral copy of the binding table and compares.
// ----------------------------------------------------------------------------
module dhcp_snoop_binding_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKETS = 16;
    localparam int WAYS    = 4;
    localparam int SLOTS   = BUCKETS * WAYS;
    localparam int N_RAND  = 526;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]     fn;
        dsbt_pkg::req_t req;
    } cmd_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;

    dhcp_snoop_binding_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) i_dut (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // binding table shadow
    logic             tbl_valid [SLOTS] = '{default: 1'b0};
    dsbt_pkg::entry_t tbl_ent   [SLOTS] = '{default: '0};
    int unsigned      tbl_rank  [SLOTS] = '{default: 0};
    logic [31:0]      now_sec = '0;

    cmd_t cmd_q[$];
    dsbt_pkg::res_t result_q[$];
    logic [47:0] known_macs[$];
    int n_sent = 0, n_got = 0, n_err = 0, n_ins = 0, n_hit = 0, n_aged = 0;
    logic hold_off;
    logic s_fire;

    function automatic int bucket_base(logic [47:0] mac);
        logic [32:0] sum;
        sum = '0;
        for (int i = 0; i < 6; i++) sum += mac[8*i +: 8];
        return int'(sum % BUCKETS) * WAYS;
    endfunction

    function automatic int find_newest(logic [47:0] mac);
        int b, best;
        b = bucket_base(mac);
        best = -1;
        for (int w = 0; w < WAYS; w++)
            if (tbl_valid[b+w] && tbl_ent[b+w].mac_addr == mac &&
                (best < 0 || tbl_rank[b+w] < tbl_rank[best])) best = b + w;
        return best;
    endfunction

    function automatic void drop_slot(int s);
        int b;
        b = (s / WAYS) * WAYS;
        tbl_valid[s] = 1'b0;
        for (int w = 0; w < WAYS; w++)
            if (tbl_valid[b+w] && tbl_rank[b+w] > tbl_rank[s]) tbl_rank[b+w]--;
    endfunction

    function automatic dsbt_pkg::res_t entry_fields(int s);
        dsbt_pkg::res_t r;
        r = '0;
        r.hit = 1'b1;
        r.found_ip = tbl_ent[s].ip_addr;
        r.found_port = tbl_ent[s].port_index;
        r.found_vlan = tbl_ent[s].vlan_id;
        r.found_lease = tbl_ent[s].lease_secs;
        r.found_state = tbl_ent[s].bind_state;
        r.found_kind = tbl_ent[s].bind_kind;
        r.found_hw_len = tbl_ent[s].hw_len;
        r.bound_time = tbl_ent[s].stamp;
        return r;
    endfunction

    function automatic dsbt_pkg::res_t predict_binding(cmd_t c);
        dsbt_pkg::res_t r;
        int s, b, fs, nb;
        logic ok;
        int unsigned aged;
        r = '0;
        case (c.fn)
            dsbt_pkg::FN_LOOKUP, dsbt_pkg::FN_DELETE: begin
                s = find_newest(c.req.mac_addr);
                if (s < 0) begin
                    r.status = dsbt_pkg::ST_NOTFOUND;
                end else begin
                    r = entry_fields(s);
                    n_hit++;
                    if (c.fn == dsbt_pkg::FN_DELETE) drop_slot(s);
                end
            end
            dsbt_pkg::FN_INSERT: begin
                b = bucket_base(c.req.mac_addr);
                fs = -1;
                for (int w = WAYS - 1; w >= 0; w--) if (!tbl_valid[b+w]) fs = b + w;
                if (fs < 0) begin
                    r.status = dsbt_pkg::ST_FULL;
                end else begin
                    for (int w = 0; w < WAYS; w++) if (tbl_valid[b+w]) tbl_rank[b+w]++;
                    tbl_valid[fs] = 1'b1;
                    tbl_ent[fs].mac_addr = c.req.mac_addr;
                    tbl_ent[fs].ip_addr = c.req.ip_addr;
                    tbl_ent[fs].port_index = c.req.port_index;
                    tbl_ent[fs].vlan_id = c.req.vlan_id;
                    tbl_ent[fs].lease_secs = c.req.lease_secs;
                    tbl_ent[fs].bind_state = c.req.bind_state;
                    tbl_ent[fs].bind_kind = c.req.bind_kind;
                    tbl_ent[fs].hw_len = c.req.hw_len;
                    tbl_ent[fs].stamp = now_sec;
                    tbl_rank[fs] = 0;
                    r = entry_fields(fs);
                    r.hit = 1'b0;
                    n_ins++;
                end
            end
            dsbt_pkg::FN_REFRESH: begin
                s = find_newest(c.req.mac_addr);
                if (s < 0) begin
                    r.status = dsbt_pkg::ST_NOTFOUND;
                end else begin
                    ok = tbl_ent[s].vlan_id == c.req.vlan_id &&
                         tbl_ent[s].hw_len == c.req.hw_len;
                    if (c.req.port_index != 0 && tbl_ent[s].port_index != c.req.port_index)
                        ok = 1'b0;
                    nb = c.req.hw_len < 6 ? int'(c.req.hw_len) : 6;
                    for (int i = 0; i < nb; i++)
                        if (tbl_ent[s].mac_addr[8*(5-i) +: 8] != c.req.mac_addr[8*(5-i) +: 8])
                            ok = 1'b0;
                    if (ok) begin
                        tbl_ent[s].bind_state = c.req.bind_state;
                        tbl_ent[s].ip_addr = c.req.ip_addr;
                        tbl_ent[s].lease_secs = c.req.lease_secs;
                        tbl_ent[s].stamp = now_sec;
                    end
                    r = entry_fields(s);
                    if (!ok) r.status = dsbt_pkg::ST_MISMATCH;
                end
            end
            dsbt_pkg::FN_TICK: begin
                aged = 0;
                now_sec = now_sec + 1;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_valid[i] &&
                        {1'b0, tbl_ent[i].stamp} + {1'b0, tbl_ent[i].lease_secs} <=
                        {1'b0, now_sec}) begin
                        drop_slot(i);
                        if (aged < 127) aged++;
                    end
                r.aged_count = aged[6:0];
                n_aged += aged;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [47:0] pick_mac();
        logic [47:0] m;
        if (known_macs.size() > 0 && $urandom_range(0, 3) != 0)
            return known_macs[$urandom_range(0, known_macs.size() - 1)];
        m = 48'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0) m[47:16] = 32'h0;
        known_macs.push_back(m);
        if (known_macs.size() > 24) void'(known_macs.pop_front());
        return m;
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] fn, logic [47:0] mac);
        cmd_t c;
        c.fn = fn;
        c.req.mac_addr = mac;
        c.req.ip_addr = $urandom;
        c.req.port_index = $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom);
        c.req.vlan_id = 12'($urandom);
        c.req.lease_secs = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 30);
        c.req.bind_state = 8'($urandom);
        c.req.bind_kind = 8'($urandom);
        c.req.hw_len = 5'($urandom_range(0, 16));
        return c;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // input handshake seen at the rising edge
    always @(posedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
    end

    // driver
    int s_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else if (!s_tvalid || s_fire) begin
            if (s_fire) n_sent++;
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                s_tuser <= cmd_q[0].fn;
                s_tdata <= {7'd0, cmd_q[0].req};
                result_q.push_back(predict_binding(cmd_q.pop_front()));
                s_tvalid <= 1'b1;
                s_gap = gap_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    int m_gap;
    always @(negedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
            m_gap = 0;
        end else if (m_gap > 0) begin
            m_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) m_gap = gap_len();
        end
    end

    // long receiver stall while commands keep coming
    initial begin
        hold_off = 1'b0;
        wait (n_sent >= 300);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (400) @(negedge aclk);
        hold_off = 1'b0;
    end

    // monitor
    dsbt_pkg::res_t got, want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(dsbt_pkg::res_t)-1:0];
            n_got++;
            if (result_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result word %h", got);
            end else begin
                want = result_q.pop_front();
                if (got !== want || m_tdata[159:$bits(dsbt_pkg::res_t)] !== '0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("word %0d: expected %h, got %h", n_got, want, got);
                end
            end
        end
    end

    // watchdog on handshake activity
    int idle_cyc = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WD_LIMIT) begin
            $display("watchdog expired, %0d words outstanding", result_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [47:0] m;
        cmd_t c;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: misses, extremes, full bucket, duplicates, refresh checks, aging
        cmd_q.push_back(make_cmd(dsbt_pkg::FN_LOOKUP, 48'h0));
        cmd_q.push_back(make_cmd(dsbt_pkg::FN_DELETE, 48'hFFFF_FFFF_FFFF));
        cmd_q.push_back(make_cmd(dsbt_pkg::FN_REFRESH, 48'h1));
        c = make_cmd(dsbt_pkg::FN_INSERT, 48'hFFFF_FFFF_FFFF);
        c.req = '1;
        c.req.hw_len = 5'd16;
        cmd_q.push_back(c);
        cmd_q.push_back(make_cmd(dsbt_pkg::FN_LOOKUP, 48'hFFFF_FFFF_FFFF));
        c = make_cmd(dsbt_pkg::FN_INSERT, 48'h0);
        c.req = '0;
        cmd_q.push_back(c);
        // same bucket as the zero MAC (byte sum 0x10) five times: the last two overflow
        for (int i = 0; i < 5; i++) begin
            c = make_cmd(dsbt_pkg::FN_INSERT, 48'h0000_0000_0010);
            c.req.hw_len = 5'd6;
            c.req.vlan_id = 12'd7;
            c.req.port_index = 16'd3;
            c.req.lease_secs = 32'd2;
            cmd_q.push_back(c);
        end
        c.fn = dsbt_pkg::FN_REFRESH; c.req.port_index = 16'd0; c.req.lease_secs = 32'd5;
        cmd_q.push_back(c);
        c.req.port_index = 16'd9;
        cmd_q.push_back(c);
        c.req.port_index = 16'd3; c.req.vlan_id = 12'd8;
        cmd_q.push_back(c);
        c.req.vlan_id = 12'd7; c.req.hw_len = 5'd4;
        cmd_q.push_back(c);
        cmd_q.push_back(make_cmd(dsbt_pkg::FN_DELETE, 48'h0000_0000_0010));
        cmd_q.push_back(make_cmd(dsbt_pkg::FN_LOOKUP, 48'h0000_0000_0010));
        for (int i = 0; i < 3; i++) cmd_q.push_back(make_cmd(dsbt_pkg::FN_TICK, 48'h0));
        for (int i = 5; i < 8; i++) cmd_q.push_back(make_cmd(3'(i), 48'h0));
        cmd_q.push_back(make_cmd(dsbt_pkg::FN_LOOKUP, 48'h0));

        for (int i = 0; i < N_RAND; i++) begin
            int p;
            p = $urandom_range(0, 99);
            m = pick_mac();
            if (p < 30) c = make_cmd(dsbt_pkg::FN_INSERT, m);
            else if (p < 50) c = make_cmd(dsbt_pkg::FN_LOOKUP, m);
            else if (p < 62) c = make_cmd(dsbt_pkg::FN_DELETE, m);
            else if (p < 85) c = make_cmd(dsbt_pkg::FN_REFRESH, m);
            else if (p < 98) c = make_cmd(dsbt_pkg::FN_TICK, m);
            else c = make_cmd(3'($urandom_range(5, 7)), m);
            cmd_q.push_back(c);
        end

        wait (cmd_q.size() == 0 && !s_tvalid);
        wait (result_q.size() == 0);
        repeat (300) @(posedge aclk);
        $display("%0d commands, %0d results; %0d inserts, %0d hits, %0d entries aged out",
                 n_sent, n_got, n_ins, n_hit, n_aged);
        if (n_err == 0 && result_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", n_err);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
